@@ design/lkv_pkg.sv @@
package lkv_pkg;

	localparam int MAX_ENTRIES = 16;
	localparam int VALUE_BITS  = 32;

	localparam int KEY_W  = 32;
	localparam int WORD_W = 32;
	localparam int CAP_W  = 5;
	localparam int STAT_W = 3;
	localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

	localparam logic REQ_ADD   = 1'b0;
	localparam logic REQ_REFER = 1'b1;

	localparam logic [STAT_W-1:0] ST_ADDED   = 3'd0;
	localparam logic [STAT_W-1:0] ST_EVICTED = 3'd1;
	localparam logic [STAT_W-1:0] ST_PRESENT = 3'd2;
	localparam logic [STAT_W-1:0] ST_HIT     = 3'd3;
	localparam logic [STAT_W-1:0] ST_MISS    = 3'd4;

	typedef logic [KEY_W-1:0]      key_t;
	typedef logic [VALUE_BITS-1:0] val_t;

endpackage

@@ design/lkv_cell.sv @@
module lkv_cell import lkv_pkg::*; (
	input  logic clk,
	input  logic en,
	input  key_t probe_key,
	input  key_t in_key,
	input  val_t in_value,
	output key_t key,
	output val_t value,
	output logic match
);

	key_t key_q;
	val_t value_q;

	// loads from the left neighbor (or the front mux for the head cell)
	always_ff @(posedge clk) begin
		if (en) begin
			key_q   <= in_key;
			value_q <= in_value;
		end
	end

	assign key   = key_q;
	assign value = value_q;
	assign match = (key_q == probe_key);

endmodule

@@ design/lru_key_value_cache.sv @@
// channel | valid     | stall     | payload
// --------+-----------+-----------+------------------------------------
// in      | in_valid  | in_stall  | req_type, key, value
// out     | out_valid | out_stall | status, read_value, evicted_key
// cfg     | cfg_we    | -         | cfg_data (capacity)
//
// an accepted request is latched in stage 1, then in the next cycle every cell
// compares its key at once and the chain shifts; the result lands in the output
// register as stage 1 advances, and a new request can be taken every cycle while
// the output register drains
// the cycle count per request is set by the single compare-and-shift step of the
// cell row, one request in flight in stage 1
// reset clears occupancy, the pipeline valids and sets capacity to 16; cell
// contents are not reset, only slots below the occupancy count are ever matched
// a stalled output holds stage 1 and the cells, so in_stall rises behind it
module lru_key_value_cache import lkv_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [CAP_W-1:0]         cfg_data,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic                     req_type,
	input  logic signed [KEY_W-1:0]  key,
	input  logic [WORD_W-1:0]        value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [STAT_W-1:0]        status,
	output logic [WORD_W-1:0]        read_value,
	output logic signed [KEY_W-1:0]  evicted_key
);

	localparam int IDX_N = MAX_ENTRIES;

	// configuration
	logic [CAP_W-1:0] capacity_q;
	logic [CMP_W-1:0] cap_eff;

	// stage 1 request
	logic busy_s1;
	logic req_s1;
	key_t key_s1;
	val_t value_s1;

	// occupancy
	logic [CNT_W-1:0] count_q;

	// output register
	logic              out_valid_q;
	logic [STAT_W-1:0] status_q;
	logic [WORD_W-1:0] read_value_q;
	key_t              evicted_key_q;

	// cell row
	key_t cell_key   [IDX_N];
	val_t cell_value [IDX_N];
	logic [IDX_N-1:0] cell_match;
	logic [IDX_N-1:0] cell_en;

	// lookup
	logic [IDX_N-1:0] hit_vec;
	logic [IDX_N-1:0] hit_first;
	logic [IDX_N-1:0] tail_sel;
	logic             hit;
	logic [CNT_W-1:0] hit_pos;
	val_t             hit_value;
	key_t             tail_key;
	key_t             front_key;
	val_t             front_value;
	logic             evict;
	logic [CNT_W-1:0] ins_pos;
	logic [CNT_W-1:0] shift_pos;
	logic             do_shift;
	logic             adv;
	logic [STAT_W-1:0] status_d;

	// stage 1 moves on once the output register has room
	assign adv      = busy_s1 && (!out_valid_q || !out_stall);
	assign in_stall = busy_s1 && !adv;

	// capacity zero acts as one, above the row size acts as the row size
	always_comb begin
		if (capacity_q == '0) begin
			cap_eff = CMP_W'(1);
		end else if (CMP_W'(capacity_q) > CMP_W'(MAX_ENTRIES)) begin
			cap_eff = CMP_W'(MAX_ENTRIES);
		end else begin
			cap_eff = CMP_W'(capacity_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAP_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_data;
		end
	end

	// only occupied slots take part in the match
	always_comb begin
		for (int i = 0; i < IDX_N; i++) begin
			hit_vec[i]  = cell_match[i] && (CNT_W'(i) < count_q);
			tail_sel[i] = (CNT_W'(i) == count_q - CNT_W'(1));
		end
	end

	// lowest matching slot, one-hot, with its index
	always_comb begin
		logic seen;
		seen      = 1'b0;
		hit_first = '0;
		hit_pos   = '0;
		for (int i = 0; i < IDX_N; i++) begin
			if (hit_vec[i] && !seen) begin
				hit_first[i] = 1'b1;
				hit_pos      = CNT_W'(i);
				seen         = 1'b1;
			end
		end
	end

	assign hit = |hit_vec;

	always_comb begin
		hit_value = '0;
		tail_key  = '0;
		for (int i = 0; i < IDX_N; i++) begin
			hit_value = hit_value | (cell_value[i] & {VALUE_BITS{hit_first[i]}});
			tail_key  = tail_key | (cell_key[i] & {KEY_W{tail_sel[i]}});
		end
	end

	// insertion slot for a new key: after dropping the least recent one if full
	always_comb begin
		logic [CNT_W-1:0] n;
		evict = (CMP_W'(count_q) >= cap_eff) && (count_q != '0);
		n     = evict ? (count_q - CNT_W'(1)) : count_q;
		if (n >= CNT_W'(MAX_ENTRIES)) begin
			n = CNT_W'(MAX_ENTRIES - 1);
		end
		ins_pos = n;
	end

	// refer hit promotes its slot, add of a new key promotes the insertion slot
	always_comb begin
		if (req_s1 == REQ_REFER) begin
			do_shift    = hit;
			shift_pos   = hit_pos;
			front_key   = key_s1;
			front_value = hit_value;
			status_d    = hit ? ST_HIT : ST_MISS;
		end else begin
			do_shift    = !hit;
			shift_pos   = ins_pos;
			front_key   = key_s1;
			front_value = value_s1;
			if (hit) begin
				status_d = ST_PRESENT;
			end else if (evict) begin
				status_d = ST_EVICTED;
			end else begin
				status_d = ST_ADDED;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < IDX_N; i++) begin
			cell_en[i] = adv && do_shift && (CNT_W'(i) <= shift_pos);
		end
	end

	// the cell row: each cell takes its left neighbor, the head takes the front entry
	for (genvar g = 0; g < IDX_N; g++) begin : g_cell
		if (g == 0) begin : g_head
			lkv_cell u_cell (
				.clk       (clk),
				.en        (cell_en[g]),
				.probe_key (key_s1),
				.in_key    (front_key),
				.in_value  (front_value),
				.key       (cell_key[g]),
				.value     (cell_value[g]),
				.match     (cell_match[g])
			);
		end else begin : g_body
			lkv_cell u_cell (
				.clk       (clk),
				.en        (cell_en[g]),
				.probe_key (key_s1),
				.in_key    (cell_key[g-1]),
				.in_value  (cell_value[g-1]),
				.key       (cell_key[g]),
				.value     (cell_value[g]),
				.match     (cell_match[g])
			);
		end
	end

	// stage 1 and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
			count_q <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				busy_s1 <= 1'b1;
			end else if (adv) begin
				busy_s1 <= 1'b0;
			end
			if (adv && (req_s1 == REQ_ADD) && !hit) begin
				count_q <= ins_pos + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_s1   <= req_type;
			key_s1   <= key;
			value_s1 <= VALUE_BITS'(value);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_q      <= status_d;
			read_value_q  <= (status_d == ST_HIT) ? WORD_W'(hit_value) : '0;
			evicted_key_q <= (status_d == ST_EVICTED) ? tail_key : '0;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = status_q;
	assign read_value  = read_value_q;
	assign evicted_key = evicted_key_q;

endmodule

@@ design/lkv_checker.sv @@
module lkv_checker import lkv_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     in_valid,
	input logic                     in_stall,
	input logic                     out_valid,
	input logic                     out_stall,
	input logic [STAT_W-1:0]        status,
	input logic [WORD_W-1:0]        read_value,
	input logic signed [KEY_W-1:0]  evicted_key
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status)
			&& $stable(read_value) && $stable(evicted_key))
		else $error("stalled result changed");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (status == ST_ADDED || status == ST_EVICTED
			|| status == ST_PRESENT || status == ST_HIT || status == ST_MISS))
		else $error("status code out of range");

	a_read_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_HIT |-> read_value == '0)
		else $error("read value without a hit");

	a_evict_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_EVICTED |-> evicted_key == '0)
		else $error("evicted key without an eviction");

	// a result needs an earlier input transfer or an earlier stalled result
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid ##1 out_valid |-> $past(in_valid && !in_stall, 2)
			|| $past(in_stall, 1))
		else $error("result without a request");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (.*);

@@ verif/tb_lru_key_value_cache.sv @@
`timescale 1ns / 1ps

import lkv_pkg::*;

typedef struct {
	logic [STAT_W-1:0] status;
	logic [WORD_W-1:0] read_value;
	key_t              evicted_key;
} cache_result_t;

// shadow copy of the recency-ordered cache plus the queue of results it predicts
class lru_shadow;
	key_t              slot_key[MAX_ENTRIES];
	val_t              slot_val[MAX_ENTRIES];
	int unsigned       fill;
	logic [CAP_W-1:0]  capacity;
	cache_result_t     pending_results[$];
	int unsigned       errors;
	int unsigned       status_seen[5];

	function new();
		fill = 0;
		capacity = CAP_RESET;
		errors = 0;
		foreach (status_seen[i]) status_seen[i] = 0;
	endfunction

	function void set_capacity(logic [CAP_W-1:0] c);
		capacity = c;
	endfunction

	function int unsigned pending();
		return pending_results.size();
	endfunction

	// slot pos becomes most recent, the ones above it slide down by one
	function void move_to_front(int pos);
		key_t k;
		val_t v;
		k = slot_key[pos];
		v = slot_val[pos];
		for (int i = pos; i > 0; i--) begin
			slot_key[i] = slot_key[i-1];
			slot_val[i] = slot_val[i-1];
		end
		slot_key[0] = k;
		slot_val[0] = v;
	endfunction

	function void note_request(logic rt, key_t k, logic [WORD_W-1:0] v);
		int pos;
		int n;
		int lim;
		cache_result_t r;
		pos = -1;
		for (int i = 0; i < fill; i++)
			if (pos < 0 && slot_key[i] == k) pos = i;
		lim = (capacity == 0) ? 1 : ((capacity > MAX_ENTRIES) ? MAX_ENTRIES : capacity);
		r.status = ST_ADDED;
		r.read_value = '0;
		r.evicted_key = '0;
		if (rt == REQ_REFER) begin
			if (pos < 0) begin
				r.status = ST_MISS;
			end else begin
				r.status = ST_HIT;
				r.read_value = WORD_W'(slot_val[pos]);
				move_to_front(pos);
			end
		end else if (pos >= 0) begin
			r.status = ST_PRESENT;
		end else begin
			n = fill;
			if (n >= lim && n > 0) begin
				r.evicted_key = slot_key[n-1];
				r.status = ST_EVICTED;
				n--;
			end
			if (n >= MAX_ENTRIES) n = MAX_ENTRIES - 1;
			slot_key[n] = k;
			slot_val[n] = val_t'(v);
			fill = n + 1;
			move_to_front(n);
		end
		pending_results.push_back(r);
	endfunction

	task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("[%0t] mismatch %0d: %s got %h expected %h", $realtime, errors, what,
			got, want);
	endtask

	task check_result(logic [STAT_W-1:0] st, logic [WORD_W-1:0] rd, key_t ev);
		cache_result_t w;
		if (pending_results.size() == 0) begin
			report_mismatch("result with nothing pending, status", 32'(st), 32'hx);
		end else begin
			w = pending_results.pop_front();
			if (st != w.status) report_mismatch("status", 32'(st), 32'(w.status));
			if (rd != w.read_value) report_mismatch("read_value", rd, w.read_value);
			if (ev != w.evicted_key) report_mismatch("evicted_key", ev, w.evicted_key);
			if (st <= ST_MISS) status_seen[st]++;
		end
	endtask
endclass

module tb_lru_key_value_cache;

	// clock, reset and block ports; the driven inputs are known from time zero
	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_we = 1'b0;
	logic [CAP_W-1:0]        cfg_data = '0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic                    req_type = REQ_ADD;
	logic signed [KEY_W-1:0] key = '0;
	logic [WORD_W-1:0]       value = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic [STAT_W-1:0]       status;
	logic [WORD_W-1:0]       read_value;
	logic signed [KEY_W-1:0] evicted_key;

	lru_key_value_cache dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.req_type   (req_type),
		.key        (key),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.read_value (read_value),
		.evicted_key(evicted_key)
	);

	// 2 ns period
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	lru_shadow shadow = new();

	// sender pacing: burst length left and the longest gap between bursts
	int burst_left = 0;
	int gap_max = 0;
	// receiver pacing: 0 never stalls, 1 short stall runs, 2 long stall runs
	int stall_mode = 0;
	int stall_left = 0;
	logic stall_now = 1'b0;
	int unsigned requests_sent = 0;

	key_t key_pool[20];

	// output side stall pattern, runs of stall and no stall of random length
	always @(posedge clk) begin
		if (!arst_n || stall_mode == 0) begin
			stall_now = 1'b0;
			stall_left = 0;
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
		end else begin
			stall_now = !stall_now;
			out_stall <= stall_now;
			if (stall_now)
				stall_left = $urandom_range((stall_mode == 2) ? 12 : 3, 0);
			else
				stall_left = $urandom_range(8, 0);
		end
	end

	// result transfers are checked against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			shadow.check_result(status, read_value, evicted_key);
	end

	// one request transfer; a gap before it when the current burst has run out
	task send_request(logic rt, key_t k, logic [WORD_W-1:0] v);
		int gap;
		if (burst_left == 0) begin
			gap = (gap_max > 0) ? $urandom_range(gap_max, 1) : 0;
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(12, 1);
		end
		burst_left--;
		in_valid <= 1'b1;
		req_type <= rt;
		key <= k;
		value <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		// transfer took place at this edge
		shadow.note_request(rt, k, v);
		requests_sent++;
	endtask

	// drain everything in flight, then a few quiet cycles
	task wait_idle();
		in_valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (shadow.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// capacity changes only while the cache is idle
	task write_capacity(logic [CAP_W-1:0] c);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_data <= c;
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow.set_capacity(c);
	endtask

	// mostly keys from a small pool so hits, evictions and re-adds happen,
	// some fully random keys for misses and bit coverage
	task random_phase(int count);
		logic rt;
		key_t k;
		for (int i = 0; i < count; i++) begin
			rt = 1'($urandom_range(1, 0));
			if ($urandom_range(99, 0) < 15)
				k = $urandom;
			else
				k = key_pool[$urandom_range(19, 0)];
			send_request(rt, k, $urandom);
		end
	endtask

	initial begin
		logic [CAP_W-1:0] phase_cap[8];

		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7fff_ffff;
		key_pool[2] = 32'h0000_0000;
		key_pool[3] = 32'hffff_ffff;
		for (int i = 4; i < 20; i++) key_pool[i] = $urandom;

		// reset held low from time zero, released at a rising edge
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: capacity at its reset value of 16
		send_request(REQ_REFER, 32'h0000_0000, 32'hffff_ffff);  // miss on empty cache
		send_request(REQ_ADD,   32'h1357_9bdf, 32'h0000_0001);
		send_request(REQ_REFER, 32'h1357_9bdf, 32'h0000_0000);  // hit on the only entry
		send_request(REQ_ADD,   32'h8000_0000, 32'hffff_ffff);
		send_request(REQ_ADD,   32'h7fff_ffff, 32'h0000_0000);
		send_request(REQ_ADD,   32'hffff_ffff, 32'ha5a5_a5a5);
		send_request(REQ_ADD,   32'h0000_0000, 32'h5a5a_5a5a);
		send_request(REQ_REFER, 32'h0000_0000, 32'h0000_0000);  // hit on the most recent
		send_request(REQ_REFER, 32'h1357_9bdf, 32'hffff_ffff);  // hit on the least recent
		send_request(REQ_REFER, 32'h1234_5678, 32'h0000_0000);  // miss
		send_request(REQ_ADD,   32'h7fff_ffff, 32'h1234_5678);  // key already present
		send_request(REQ_REFER, 32'h7fff_ffff, 32'h0000_0000);  // keeps the first value

		// capacity dropped below occupancy: one eviction per add, occupancy holds
		write_capacity(CAP_W'(1));
		send_request(REQ_ADD,   32'hdead_beef, 32'hcafe_f00d);
		send_request(REQ_REFER, 32'h8000_0000, 32'h0000_0000);
		send_request(REQ_ADD,   32'h2468_ace0, 32'h8000_0001);

		// zero capacity behaves as one
		write_capacity(CAP_W'(0));
		send_request(REQ_ADD,   32'h0f0f_0f0f, 32'hf0f0_f0f0);
		send_request(REQ_REFER, 32'h0f0f_0f0f, 32'h0000_0000);
		send_request(REQ_REFER, 32'hdead_beef, 32'h0000_0000);

		// random phases over several capacities, the top of the field among them
		phase_cap[0] = CAP_W'(2);
		phase_cap[1] = CAP_W'(31);
		phase_cap[2] = CAP_W'(17);
		phase_cap[3] = CAP_W'(16);
		phase_cap[4] = CAP_W'(1);
		phase_cap[5] = CAP_W'($urandom_range(31, 0));
		phase_cap[6] = CAP_W'(0);
		phase_cap[7] = CAP_W'($urandom_range(31, 0));
		for (int p = 0; p < 8; p++) begin
			write_capacity(phase_cap[p]);
			// pacing differs per phase, some phases run without any idling
			gap_max = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 3 : 8);
			stall_mode = p % 3;
			if (p == 7) begin
				gap_max = 0;
				stall_mode = 0;
			end
			random_phase(48);
		end

		wait_idle();
		repeat (8) @(posedge clk);

		$display("covered %0d requests: %0d added, %0d added with eviction, %0d already present",
			requests_sent, shadow.status_seen[ST_ADDED], shadow.status_seen[ST_EVICTED],
			shadow.status_seen[ST_PRESENT]);
		$display("refers: %0d hits, %0d misses; capacities swept from 0 to 31",
			shadow.status_seen[ST_HIT], shadow.status_seen[ST_MISS]);
		if (shadow.errors == 0 && shadow.pending() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	// guard against a hung handshake
	initial begin
		#1_000_000;
		$display("timeout with %0d results still pending", shadow.pending());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ lru_key_value_cache.f @@
design/lkv_pkg.sv
design/lkv_cell.sv
design/lru_key_value_cache.sv
design/lkv_checker.sv
verif/tb_lru_key_value_cache.sv
